>>> rtl/core/rswf_pkg.sv
// Shared types, command codes and helper functions for the state write filter.
package rswf_pkg;

  localparam logic [2:0] CMD_RENDER    = 3'd0;
  localparam logic [2:0] CMD_TEX_BIND  = 3'd1;
  localparam logic [2:0] CMD_STAGE     = 3'd2;
  localparam logic [2:0] CMD_SAMPLER   = 3'd3;
  localparam logic [2:0] CMD_DEV_RESET = 3'd4;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd5;

  localparam int FORCED_COUNT = 8;
  localparam logic [8:0] FORCED_STATES [FORCED_COUNT] = '{
    9'd7, 9'd14, 9'd15, 9'd19, 9'd20, 9'd24, 9'd25, 9'd27
  };

  typedef struct packed {
    logic [2:0]  cmd;
    logic [8:0]  slot;
    logic [5:0]  state_type;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic        pass_on;
    logic [2:0]  kind_out;
    logic [8:0]  slot_out;
    logic [5:0]  type_out;
    logic [31:0] value_out;
  } result_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] val;
  } entry_t;

  typedef struct packed {
    logic load;
    logic check;
    logic sweep;
  } ctl_t;

  typedef struct packed {
    logic       sweep_last;
    logic [2:0] kind;
  } sts_t;

  function automatic logic is_forced(input logic [8:0] s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < FORCED_COUNT; i++) begin
      if (FORCED_STATES[i] == s) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

>>> rtl/core/redundant_state_write_filter.sv
// Top level of the redundant state write filter.
// An item is taken when start is high and busy is low, and its result is registered onto
// result with done high for one cycle; the receiver cannot stall. Each item has two steps
// (table read, then compare and write back), and busy is high during the compare, so no
// new item is taken until the last has been compared. After reset, and after a device
// reset or clear-all item, the block sweeps the render, stage and sampler tables one
// entry per cycle to clear their valid bits, holding busy high until the largest depth
// of RENDER_SLOTS, STAGE_COUNT * STAGE_TYPES and SAMPLER_SLOTS * SAMPLER_KINDS is swept.
module redundant_state_write_filter #(
  parameter int RENDER_SLOTS  = 256,
  parameter int STAGE_COUNT   = 8,
  parameter int STAGE_TYPES   = 33,
  parameter int SAMPLER_SLOTS = 16,
  parameter int SAMPLER_KINDS = 14,
  parameter int TEXTURE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rswf_pkg::item_t   item,
  output logic              done,
  output rswf_pkg::result_t result
);
  import rswf_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rswf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  rswf_datapath #(
    .RENDER_SLOTS  (RENDER_SLOTS),
    .STAGE_COUNT   (STAGE_COUNT),
    .STAGE_TYPES   (STAGE_TYPES),
    .SAMPLER_SLOTS (SAMPLER_SLOTS),
    .SAMPLER_KINDS (SAMPLER_KINDS),
    .TEXTURE_SLOTS (TEXTURE_SLOTS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

endmodule

>>> rtl/core/rswf_ctrl.sv
// Controller state machine that sequences accept, compare and table sweeps.
module rswf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rswf_pkg::sts_t  sts,
  output rswf_pkg::ctl_t  ctl,
  output logic            busy
);
  import rswf_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    unique case (state)
      S_SWEEP: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.check = 1'b1;
        if (sts.kind == CMD_DEV_RESET || sts.kind == CMD_CLEAR_ALL) begin
          state_next = S_SWEEP;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/rswf_datapath.sv
// Datapath with the shadow tables, compare logic and result register.
module rswf_datapath #(
  parameter int RENDER_SLOTS  = 256,
  parameter int STAGE_COUNT   = 8,
  parameter int STAGE_TYPES   = 33,
  parameter int SAMPLER_SLOTS = 16,
  parameter int SAMPLER_KINDS = 14,
  parameter int TEXTURE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  rswf_pkg::item_t   item,
  input  rswf_pkg::ctl_t    ctl,
  output rswf_pkg::sts_t    sts,
  output rswf_pkg::result_t result,
  output logic              done
);
  import rswf_pkg::*;

  localparam int STAGE_ENTRIES   = STAGE_COUNT * STAGE_TYPES;
  localparam int SAMPLER_ENTRIES = SAMPLER_SLOTS * SAMPLER_KINDS;
  localparam int MAX_RS   = (RENDER_SLOTS > STAGE_ENTRIES) ? RENDER_SLOTS : STAGE_ENTRIES;
  localparam int CLR_DEPTH = (MAX_RS > SAMPLER_ENTRIES) ? MAX_RS : SAMPLER_ENTRIES;
  localparam int RAW = $clog2(RENDER_SLOTS);
  localparam int SAW = (STAGE_ENTRIES > 1) ? $clog2(STAGE_ENTRIES) : 1;
  localparam int MAW = (SAMPLER_ENTRIES > 1) ? $clog2(SAMPLER_ENTRIES) : 1;
  localparam int TW  = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
  localparam int CW  = $clog2(CLR_DEPTH);

  entry_t r_mem [RENDER_SLOTS];
  entry_t s_mem [STAGE_ENTRIES];
  entry_t m_mem [SAMPLER_ENTRIES];
  logic [31:0] tex_val [TEXTURE_SLOTS];
  logic [TEXTURE_SLOTS-1:0] tex_ok;

  item_t           item_q;
  entry_t          r_rd, s_rd, m_rd;
  logic [RAW-1:0]  r_idx;
  logic [SAW-1:0]  s_idx;
  logic [MAW-1:0]  m_idx;
  logic [TW-1:0]   t_idx;
  logic            r_in, s_in, m_in, t_in, forced;
  logic [CW-1:0]   cnt;

  logic [10:0]     s_full, m_full;
  logic            pass;
  logic            r_we, s_we, m_we;
  logic [RAW-1:0]  r_wa;
  logic [SAW-1:0]  s_wa;
  logic [MAW-1:0]  m_wa;
  entry_t          wd;

  assign s_full = 11'(item.slot) * 11'(STAGE_TYPES) + 11'(item.state_type);
  assign m_full = 11'(item.slot) * 11'(SAMPLER_KINDS) + 11'(item.state_type);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_q <= item;
      r_idx  <= item.slot[RAW-1:0];
      s_idx  <= s_full[SAW-1:0];
      m_idx  <= m_full[MAW-1:0];
      t_idx  <= item.slot[TW-1:0];
      r_in   <= 10'(item.slot) < 10'(RENDER_SLOTS);
      s_in   <= (10'(item.slot) < 10'(STAGE_COUNT)) &&
                (7'(item.state_type) < 7'(STAGE_TYPES));
      m_in   <= (10'(item.slot) < 10'(SAMPLER_SLOTS)) &&
                (7'(item.state_type) < 7'(SAMPLER_KINDS));
      t_in   <= 10'(item.slot) < 10'(TEXTURE_SLOTS);
      forced <= is_forced(item.slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || !ctl.sweep) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CW'(1);
    end
  end

  assign sts.sweep_last = (cnt == CW'(CLR_DEPTH - 1));
  assign sts.kind       = item_q.cmd;

  always_comb begin
    pass = 1'b1;
    case (item_q.cmd)
      CMD_RENDER:    pass = !(r_in && !forced && r_rd.ok && r_rd.val == item_q.value);
      CMD_TEX_BIND:  pass = !(t_in && tex_ok[t_idx] && tex_val[t_idx] == item_q.value);
      CMD_STAGE:     pass = !(s_in && s_rd.ok && s_rd.val == item_q.value);
      CMD_SAMPLER:   pass = !(m_in && m_rd.ok && m_rd.val == item_q.value);
      CMD_CLEAR_ALL: pass = 1'b0;
      default:       pass = 1'b1;
    endcase
  end

  always_comb begin
    if (ctl.sweep) begin
      wd   = '0;
      r_we = 32'(cnt) < RENDER_SLOTS;
      s_we = 32'(cnt) < STAGE_ENTRIES;
      m_we = 32'(cnt) < SAMPLER_ENTRIES;
      r_wa = cnt[RAW-1:0];
      s_wa = cnt[SAW-1:0];
      m_wa = cnt[MAW-1:0];
    end else begin
      wd.ok  = 1'b1;
      wd.val = item_q.value;
      r_we   = ctl.check && pass && r_in && item_q.cmd == CMD_RENDER;
      s_we   = ctl.check && pass && s_in && item_q.cmd == CMD_STAGE;
      m_we   = ctl.check && pass && m_in && item_q.cmd == CMD_SAMPLER;
      r_wa   = r_idx;
      s_wa   = s_idx;
      m_wa   = m_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) r_mem[r_wa] <= wd;
    if (ctl.load) r_rd <= r_mem[item.slot[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_wa] <= wd;
    if (ctl.load) s_rd <= s_mem[s_full[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (m_we) m_mem[m_wa] <= wd;
    if (ctl.load) m_rd <= m_mem[m_full[MAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.check && pass && t_in && item_q.cmd == CMD_TEX_BIND) begin
      tex_val[t_idx] <= item_q.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_ok <= '0;
    end else if (ctl.check && item_q.cmd == CMD_CLEAR_ALL) begin
      tex_ok <= '0;
    end else if (ctl.check && pass && t_in && item_q.cmd == CMD_TEX_BIND) begin
      tex_ok[t_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.check) begin
      result.pass_on   <= pass;
      result.kind_out  <= item_q.cmd;
      result.slot_out  <= item_q.slot;
      result.type_out  <= item_q.state_type;
      result.value_out <= item_q.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.check;
    end
  end

endmodule
